// File: design/servo_slew_ramp_with_pulse_lookup_core_assert.svh
// Assertion macros for the servo slew ramp core.
`ifndef SERVO_SLEW_RAMP_WITH_PULSE_LOOKUP_CORE_ASSERT_SVH
`define SERVO_SLEW_RAMP_WITH_PULSE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSRPL_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo ramp core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSRPL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo ramp core check failed");

`endif

// File: design/ssrpl_pkg.sv
// Shared types, constants and codes for the servo slew ramp core.
package ssrpl_pkg;

  // Sizes
  localparam int TABLE_DEPTH    = 64;
  localparam int TBL_AW         = $clog2(TABLE_DEPTH);
  localparam int INIT_SETPOINTS = 10;
  localparam int INIT_W         = 4;
  localparam int ANGLE_W        = 16;
  localparam int PULSE_W        = 12;
  localparam int STEP_W         = 13;
  localparam int ENTRIES_W      = 7;
  localparam int TICK_W         = 16;
  localparam int MOVED_W        = TICK_W + STEP_W;
  localparam int DIFF_W         = ANGLE_W + 1;
  localparam int ENTRY_W        = ANGLE_W + PULSE_W;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  // Operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SETPOINT = 2'd1;
  localparam logic [1:0] OP_LOAD     = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ANGLE_LOW  = 2'd0;
  localparam logic [1:0] REG_ANGLE_HIGH = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP  = 2'd2;
  localparam logic [1:0] REG_ENTRIES    = 2'd3;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] RST_ANGLE_LOW  = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] RST_ANGLE_HIGH = 16'sd12616;
  localparam logic [STEP_W-1:0]         RST_RAMP_STEP  = 13'd129;
  localparam logic [ENTRIES_W-1:0]      RST_ENTRIES    = 7'd1;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [ANGLE_W-1:0] setpoint_angle;
    logic [TBL_AW-1:0]         entry_index;
    logic signed [ANGLE_W-1:0] entry_angle;
    logic [PULSE_W-1:0]        entry_pulse;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0]        pulse_width;
    logic signed [ANGLE_W-1:0] command_angle;
  } out_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_low_limit;
    logic signed [ANGLE_W-1:0] angle_high_limit;
    logic [STEP_W-1:0]         ramp_step;
    logic [ENTRIES_W-1:0]      table_entries;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMD,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic setpoint;
    logic load;
    logic tick;
    logic mul;
    logic cmd;
    logic scan;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: design/servo_slew_ramp_with_pulse_lookup_core.sv
// Top level: configuration registers, controller and datapath of the servo ramp core.
// Setpoint, table load and idle ticks complete on acceptance; the next item may follow at once.
// An active tick steps through the MUL, CMD, SCAN and DONE states; its scan reads one entry per cycle
// through the single read port of the pulse table.
// A result waits in an output register; a later tick stalls in its DONE state until taken.
// Synchronous active-low reset clears ramp state and control, sets registers to reset values; table unset.
module servo_slew_ramp_with_pulse_lookup_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssrpl_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssrpl_pkg::out_item_t         out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssrpl_pkg::PADDR_W-1:0] paddr,
  input  logic [ssrpl_pkg::PDATA_W-1:0] pwdata,
  output logic [ssrpl_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import ssrpl_pkg::*;

  `include "servo_slew_ramp_with_pulse_lookup_core_assert.svh"

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_low_limit  <= RST_ANGLE_LOW;
      cfg_r.angle_high_limit <= RST_ANGLE_HIGH;
      cfg_r.ramp_step        <= RST_RAMP_STEP;
      cfg_r.table_entries    <= RST_ENTRIES;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ANGLE_LOW:  cfg_r.angle_low_limit  <= $signed(pwdata[ANGLE_W-1:0]);
        REG_ANGLE_HIGH: cfg_r.angle_high_limit <= $signed(pwdata[ANGLE_W-1:0]);
        REG_RAMP_STEP:  cfg_r.ramp_step        <= pwdata[STEP_W-1:0];
        REG_ENTRIES:    cfg_r.table_entries    <= pwdata[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[3:2])
      REG_ANGLE_LOW:  prdata = PDATA_W'($unsigned(cfg_r.angle_low_limit));
      REG_ANGLE_HIGH: prdata = PDATA_W'($unsigned(cfg_r.angle_high_limit));
      REG_RAMP_STEP:  prdata = PDATA_W'(cfg_r.ramp_step);
      REG_ENTRIES:    prdata = PDATA_W'(cfg_r.table_entries);
      default:        prdata = '0;
    endcase
  end

  ssrpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssrpl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_item   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  // Never overwrite a result that has not been taken
  `SSRPL_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, sts.out_free)
  // A loaded result is presented in the next cycle
  `SSRPL_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid)
  // An active tick closes the input while its scan runs
  `SSRPL_ASSERT_NEXT(a_tick_busy, clk, rst_n,
    in_valid && in_ready && (in_data.op == OP_TICK) && sts.init_done, !in_ready)

endmodule

// File: design/ssrpl_ctrl.sv
// Controller state machine: sequences tick work and decodes input operations.
module ssrpl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  ssrpl_pkg::dp_sts_t sts,
  output ssrpl_pkg::dp_cmd_t cmd
);
  import ssrpl_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_TICK) && sts.init_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_CMD;
      ST_CMD:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: decode the accepted operation and the per-state commands
  always_comb begin
    cmd = '0;
    if (in_fire) begin
      unique case (in_op)
        OP_TICK:     cmd.tick     = sts.init_done;
        OP_SETPOINT: cmd.setpoint = 1'b1;
        OP_LOAD:     cmd.load     = 1'b1;
        default:     cmd          = '0;
      endcase
    end
    unique case (state_r)
      ST_IDLE: ;
      ST_MUL:  cmd.mul = 1'b1;
      ST_CMD:  cmd.cmd = 1'b1;
      ST_SCAN: cmd.scan = 1'b1;
      ST_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: design/ssrpl_dp.sv
// Datapath: setpoint clamp, ramp arithmetic, pulse table and nearest-angle scan.
module ssrpl_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssrpl_pkg::cfg_t      cfg,
  input  ssrpl_pkg::in_item_t  in_item,
  input  ssrpl_pkg::dp_cmd_t   cmd,
  output ssrpl_pkg::dp_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssrpl_pkg::out_item_t out_item
);
  import ssrpl_pkg::*;

  // Ramp state
  logic signed [ANGLE_W-1:0] command_now_r;
  logic signed [ANGLE_W-1:0] ramp_origin_r;
  logic signed [ANGLE_W-1:0] target_now_r;
  logic signed [ANGLE_W-1:0] target_seen_r;
  logic [INIT_W-1:0]         init_count_r;
  logic [TICK_W-1:0]         ticks_r;
  logic                      ramp_started_r;
  logic                      init_done;

  // Ramp arithmetic
  logic [MOVED_W-1:0]        moved_r;
  logic signed [DIFF_W-1:0]  delta_r;
  logic [DIFF_W-1:0]         span_abs;
  logic signed [ANGLE_W-1:0] clamped;
  logic signed [ANGLE_W-1:0] command_nxt;

  // Table and scan
  logic [ENTRY_W-1:0]        mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]        rdata_r;
  logic [ENTRIES_W-1:0]      rd_idx_r;
  logic                      rd_vld_r;
  logic                      cmp_first_r;
  logic [ENTRIES_W-1:0]      n_eff;
  logic signed [ANGLE_W-1:0] rd_angle;
  logic [DIFF_W-1:0]         rd_diff;
  logic [DIFF_W-1:0]         near_diff_r;
  logic [PULSE_W-1:0]        best_pulse_r;

  // Result register
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  assign init_done = (init_count_r >= INIT_W'(INIT_SETPOINTS));

  // Clamp the angle; with inverted limits, below low gives low, all else gives high
  always_comb begin
    if ($signed(in_item.setpoint_angle) < $signed(cfg.angle_low_limit)) begin
      clamped = cfg.angle_low_limit;
    end else if ($signed(in_item.setpoint_angle) > $signed(cfg.angle_high_limit)) begin
      clamped = cfg.angle_high_limit;
    end else begin
      clamped = in_item.setpoint_angle;
    end
  end

  // Interpolate between origin and target, else hold the target
  always_comb begin
    span_abs = delta_r[DIFF_W-1] ? DIFF_W'(-delta_r) : DIFF_W'(delta_r);
    if (ramp_started_r && (moved_r < MOVED_W'(span_abs))) begin
      if (delta_r[DIFF_W-1]) begin
        command_nxt = ramp_origin_r - $signed(moved_r[ANGLE_W-1:0]);
      end else begin
        command_nxt = ramp_origin_r + $signed(moved_r[ANGLE_W-1:0]);
      end
    end else begin
      command_nxt = target_now_r;
    end
  end

  // Update ramp state on setpoints, active ticks and the command step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_now_r  <= '0;
      ramp_origin_r  <= '0;
      target_now_r   <= '0;
      target_seen_r  <= '0;
      init_count_r   <= '0;
      ticks_r        <= '0;
      ramp_started_r <= 1'b0;
    end else begin
      if (cmd.setpoint) begin
        if (!init_done) begin
          target_seen_r <= clamped;
          command_now_r <= clamped;
          init_count_r  <= init_count_r + INIT_W'(1);
        end
        target_now_r <= clamped;
      end
      if (cmd.tick) begin
        if (target_now_r != target_seen_r) begin
          ticks_r        <= '0;
          ramp_origin_r  <= command_now_r;
          target_seen_r  <= target_now_r;
          ramp_started_r <= 1'b1;
        end else if (ticks_r != '1) begin
          ticks_r <= ticks_r + TICK_W'(1);
        end
      end
      if (cmd.cmd) begin
        command_now_r <= command_nxt;
      end
    end
  end

  // Register the ramp distance travelled and the ramp span
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      moved_r <= MOVED_W'(ticks_r) * MOVED_W'(cfg.ramp_step);
      delta_r <= DIFF_W'(target_now_r) - DIFF_W'(ramp_origin_r);
    end
  end

  // Saturate the entry count to the table, raising zero to one
  always_comb begin
    if (cfg.table_entries == '0) begin
      n_eff = ENTRIES_W'(1);
    end else if (cfg.table_entries > ENTRIES_W'(TABLE_DEPTH)) begin
      n_eff = ENTRIES_W'(TABLE_DEPTH);
    end else begin
      n_eff = cfg.table_entries;
    end
  end

  // Write loaded entries, read one entry per cycle for the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_item.entry_index] <= {in_item.entry_angle, in_item.entry_pulse};
    end
    rdata_r <= mem[rd_idx_r[TBL_AW-1:0]];
  end

  // Advance the scan address and track read data validity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      cmp_first_r <= 1'b0;
    end else if (cmd.cmd) begin
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld_r    <= (rd_idx_r < n_eff);
      cmp_first_r <= (rd_idx_r == '0);
      if (rd_idx_r < n_eff) begin
        rd_idx_r <= rd_idx_r + ENTRIES_W'(1);
      end
    end
  end

  // Distance from the command to the entry just read
  always_comb begin
    rd_angle = $signed(rdata_r[ENTRY_W-1:PULSE_W]);
    if (rd_angle > command_now_r) begin
      rd_diff = DIFF_W'(rd_angle) - DIFF_W'(command_now_r);
    end else begin
      rd_diff = DIFF_W'(command_now_r) - DIFF_W'(rd_angle);
    end
  end

  // Keep the first nearest entry
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_vld_r && (cmp_first_r || (rd_diff < near_diff_r))) begin
      near_diff_r  <= rd_diff;
      best_pulse_r <= rdata_r[PULSE_W-1:0];
    end
  end

  // Result register: load when free, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.pulse_width   <= best_pulse_r;
      out_item_r.command_angle <= command_now_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign sts.init_done = init_done;
  assign sts.scan_done = (rd_idx_r == n_eff) && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
